[rtl/pti_pkg.sv]
// Package: payload types, configuration indexes and fixed-point constants for particle impact.
package pti_pkg;

    localparam int CoordWidth  = 16;
    localparam int FracBits    = 8;
    localparam int NormFrac    = 14;
    localparam int NormWidth   = 16;
    localparam int OffsetFrac  = 16;
    localparam int InvFrac     = 16;
    localparam int CfgIdxWidth = 3;
    localparam int CfgDataWidth = 48;

    localparam logic [CfgIdxWidth-1:0] CFG_VERTEX_A     = 3'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_EDGE_AB      = 3'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_EDGE_AC      = 3'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_UNIT_NORMAL  = 3'd3;
    localparam logic [CfgIdxWidth-1:0] CFG_PLANE_OFFSET = 3'd4;
    localparam logic [CfgIdxWidth-1:0] CFG_INV_GRAM     = 3'd5;
    localparam logic [CfgIdxWidth-1:0] CFG_HIT_RADIUS   = 3'd6;

    localparam logic [15:0] RadiusReset = 16'd256;

    typedef struct packed {
        logic signed [CoordWidth-1:0] vel_z;
        logic signed [CoordWidth-1:0] vel_y;
        logic signed [CoordWidth-1:0] vel_x;
        logic signed [CoordWidth-1:0] pos_z;
        logic signed [CoordWidth-1:0] pos_y;
        logic signed [CoordWidth-1:0] pos_x;
    } t_in;

    typedef struct packed {
        logic                         hit;
        logic signed [CoordWidth-1:0] new_vel_z;
        logic signed [CoordWidth-1:0] new_vel_y;
        logic signed [CoordWidth-1:0] new_vel_x;
    } t_out;

    typedef struct packed {
        logic [47:0]        vertex_a;
        logic [47:0]        edge_ab;
        logic [47:0]        edge_ac;
        logic [47:0]        unit_normal;
        logic signed [31:0] plane_offset;
        logic [31:0]        inv_gram;
        logic [15:0]        hit_radius;
    } t_cfg;

endpackage

[rtl/pti_core.sv]
// Core: pipelined plane distance, barycentric inside test and reflection with stall control.
module pti_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pti_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    output logic          o_ready,
    input  pti_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output pti_pkg::t_out o_data
);
    import pti_pkg::*;

    localparam int NS = 10;

    logic [NS-1:0] r_v;
    logic [NS-1:0] adv;

    always_comb begin
        adv[NS-1] = !r_v[NS-1] || i_ready;
        for (int k = NS-2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end
    assign o_ready = adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (adv[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    logic signed [15:0] p [3], v [3], a [3], e1 [3], e2 [3], n [3];
    always_comb begin
        p[0] = i_data.pos_x; p[1] = i_data.pos_y; p[2] = i_data.pos_z;
        v[0] = i_data.vel_x; v[1] = i_data.vel_y; v[2] = i_data.vel_z;
        for (int d = 0; d < 3; d++) begin
            a[d]  = i_cfg.vertex_a[16*d +: 16];
            e1[d] = i_cfg.edge_ab[16*d +: 16];
            e2[d] = i_cfg.edge_ac[16*d +: 16];
            n[d]  = i_cfg.unit_normal[16*d +: 16];
        end
    end

    // stage 0: lane products
    logic signed [31:0] r0_np [3], r0_an [3];
    logic signed [15:0] r0_p [3], r0_v [3];
    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            for (int d = 0; d < 3; d++) begin
                r0_np[d] <= n[d] * p[d];
                r0_an[d] <= n[d] * a[d];
                r0_p[d]  <= p[d];
                r0_v[d]  <= v[d];
            end
        end
    end

    // stage 1: plane distance and side
    logic signed [38:0] s1, r1_s;
    logic signed [35:0] side1, r1_side;
    logic signed [15:0] r1_p [3], r1_v [3];
    always_comb begin
        s1 = 39'(r0_np[0]) + 39'(r0_np[1]) + 39'(r0_np[2])
           + (39'(i_cfg.plane_offset) <<< (FracBits + NormFrac - OffsetFrac));
        side1 = 36'(r0_an[0]) + 36'(r0_an[1]) + 36'(r0_an[2])
              - 36'(r0_np[0]) - 36'(r0_np[1]) - 36'(r0_np[2]);
    end
    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r1_s <= s1;
            r1_side <= side1;
            r1_p <= r0_p;
            r1_v <= r0_v;
        end
    end

    // stage 2: magnitude, radius check, signed distance
    logic signed [35:0] r2_sd;
    logic               r2_near;
    logic signed [15:0] r2_p [3], r2_v [3];
    logic        [37:0] dist2;
    always_comb begin
        dist2 = r1_s[38] ? 38'(-r1_s) : 38'(r1_s);
    end
    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r2_near <= dist2 <= ({22'd0, i_cfg.hit_radius} << NormFrac);
            r2_sd <= (r1_side > 0) ? -$signed({1'b0, dist2[34:0]})
                                   : $signed({1'b0, dist2[34:0]});
            r2_p <= r1_p;
            r2_v <= r1_v;
        end
    end

    // stage 3: offset products and velocity dot
    logic signed [52:0] r3_off [3];
    logic signed [31:0] r3_vn [3];
    logic               r3_near;
    logic signed [15:0] r3_p [3], r3_v [3];
    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            for (int d = 0; d < 3; d++) begin
                r3_off[d] <= r2_sd * n[d];
                r3_vn[d]  <= r2_v[d] * n[d];
            end
            r3_near <= r2_near;
            r3_p <= r2_p;
            r3_v <= r2_v;
        end
    end

    // stage 4: projected point W
    logic signed [54:0] w4 [3];
    logic signed [54:0] r4_w [3];
    logic signed [33:0] r4_len;
    logic               r4_near;
    logic signed [15:0] r4_v [3];
    always_comb begin
        for (int d = 0; d < 3; d++) begin
            w4[d] = ((55'(r3_p[d]) - 55'(a[d])) <<< FracBits)
                  - ((55'(r3_off[d]) + (55'sd1 <<< (2*NormFrac-FracBits-1)))
                     >>> (2*NormFrac-FracBits));
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r4_w <= w4;
            r4_len <= 34'(r3_vn[0]) + 34'(r3_vn[1]) + 34'(r3_vn[2]);
            r4_near <= r3_near;
            r4_v <= r3_v;
        end
    end

    // stage 5: edge dots, reflection products
    logic signed [72:0] r5_r2 [3], r5_r3 [3];
    logic signed [50:0] r5_t [3];
    logic               r5_near;
    logic signed [15:0] r5_v [3];
    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            for (int d = 0; d < 3; d++) begin
                r5_r2[d] <= e1[d] * r4_w[d];
                r5_r3[d] <= e2[d] * r4_w[d];
                r5_t[d]  <= (51'(r4_len) <<< 1) * n[d];
            end
            r5_near <= r4_near;
            r5_v <= r4_v;
        end
    end

    // stage 6: round edge dots, Gram terms, new velocity
    logic signed [74:0] r2s, r3s;
    logic signed [28:0] r6_p2, r6_p3;
    logic signed [33:0] r6_sq2, r6_sq3, r6_d23;
    logic               r6_near;
    logic signed [15:0] r6_nv [3], r6_v [3];
    logic signed [51:0] t6 [3];
    logic signed [15:0] nv6 [3];
    always_comb begin
        r2s = 75'(r5_r2[0]) + 75'(r5_r2[1]) + 75'(r5_r2[2]) + (75'sd1 <<< (2*FracBits-1));
        r3s = 75'(r5_r3[0]) + 75'(r5_r3[1]) + 75'(r5_r3[2]) + (75'sd1 <<< (2*FracBits-1));
        for (int d = 0; d < 3; d++) begin
            t6[d] = ((52'(r5_t[d]) + (52'sd1 <<< (2*NormFrac-1))) >>> (2*NormFrac))
                  - 52'(r5_v[d]);
            if (t6[d] > 52'sd32767) nv6[d] = 16'sh7fff;
            else if (t6[d] < -52'sd32768) nv6[d] = 16'sh8000;
            else nv6[d] = t6[d][15:0];
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv[6]) begin
            r6_p2 <= 29'(r2s >>> (2*FracBits));
            r6_p3 <= 29'(r3s >>> (2*FracBits));
            r6_sq2 <= 34'(e1[0]*e1[0]) + 34'(e1[1]*e1[1]) + 34'(e1[2]*e1[2]);
            r6_sq3 <= 34'(e2[0]*e2[0]) + 34'(e2[1]*e2[1]) + 34'(e2[2]*e2[2]);
            r6_d23 <= 34'(e1[0]*e2[0]) + 34'(e1[1]*e2[1]) + 34'(e1[2]*e2[2]);
            r6_near <= r5_near;
            r6_nv <= nv6;
            r6_v <= r5_v;
        end
    end

    // stage 7: numerator products
    logic signed [62:0] r7_a, r7_b, r7_c, r7_e;
    logic               r7_near;
    logic signed [15:0] r7_nv [3], r7_v [3];
    always_ff @(posedge i_clk) begin
        if (adv[7]) begin
            r7_a <= r6_sq3 * r6_p2;
            r7_b <= r6_d23 * r6_p3;
            r7_c <= r6_sq2 * r6_p3;
            r7_e <= r6_d23 * r6_p2;
            r7_near <= r6_near;
            r7_nv <= r6_nv;
            r7_v <= r6_v;
        end
    end

    // stage 8: numerators, signs and sum range
    logic signed [94:0] nv8, nu8, sum8;
    logic               r8_pos, r8_zero, r8_big, r8_near;
    logic        [39:0] r8_sum;
    logic signed [15:0] r8_nv [3], r8_v [3];
    always_comb begin
        nv8 = 95'(r7_a) - 95'(r7_b);
        nu8 = 95'(r7_c) - 95'(r7_e);
        sum8 = nu8 + nv8;
    end
    always_ff @(posedge i_clk) begin
        if (adv[8]) begin
            r8_pos <= !nu8[94] && !nv8[94];
            r8_zero <= sum8 <= 0;
            r8_big <= !sum8[94] && (sum8[93:40] != '0);
            r8_sum <= sum8[39:0];
            r8_near <= r7_near;
            r8_nv <= r7_nv;
            r8_v <= r7_v;
        end
    end

    // stage 9: inside test; sum * inv <= 2^k - 1 replaces the floor quotient
    logic [63:0] plo9;
    logic [39:0] phi9;
    logic [71:0] prod9;
    logic        inside9, hit9;
    always_comb begin
        plo9 = 64'(r8_sum[31:0]) * 64'(i_cfg.inv_gram);
        phi9 = 40'(r8_sum[39:32]) * 40'(i_cfg.inv_gram);
        prod9 = 72'(plo9) + {phi9, 32'd0};
        if (i_cfg.inv_gram == '0) inside9 = 1'b1;
        else inside9 = r8_pos
            && (r8_zero || (!r8_big && prod9 < (72'd1 << (3*FracBits + InvFrac))));
        hit9 = r8_near && inside9;
    end
    always_ff @(posedge i_clk) begin
        if (adv[9]) begin
            o_data.hit <= hit9;
            o_data.new_vel_x <= hit9 ? r8_nv[0] : r8_v[0];
            o_data.new_vel_y <= hit9 ? r8_nv[1] : r8_v[1];
            o_data.new_vel_z <= hit9 ? r8_nv[2] : r8_v[2];
        end
    end
    assign o_valid = r_v[NS-1];

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("empty pipe refused request");
    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv[9] && r_v[8] && !r8_near |=> !o_data.hit)
        else $error("far particle marked hit");
`endif
endmodule

[rtl/particle_triangle_impact_top.sv]
// Top level: configuration registers and the particle impact pipeline.
//  channel | valid     | ready     | payload
//  input   | i_valid   | o_ready   | i_data (t_in)
//  result  | o_valid   | i_ready   | o_data (t_out)
//  config  | i_cfg_valid | o_cfg_ready | i_cfg_index, i_cfg_data
// One request per cycle while the output is not stalled; ten register stages, stage 0 through stage 9.
// Throughput is set by the pipeline, each stage holding a short slice of the arithmetic.
// Reset clears all valid bits and loads register defaults (radius 1.0).
// A stall at the output holds each full stage with no empty stage after it; empty stages still fill.
module particle_triangle_impact_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  pti_pkg::t_in                      i_data,
    output logic                              o_valid,
    input  logic                              i_ready,
    output pti_pkg::t_out                     o_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pti_pkg::CfgIdxWidth-1:0]   i_cfg_index,
    input  logic [pti_pkg::CfgDataWidth-1:0]  i_cfg_data
);
    import pti_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{hit_radius: RadiusReset, default: '0};
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_VERTEX_A:     r_cfg.vertex_a <= i_cfg_data;
                CFG_EDGE_AB:      r_cfg.edge_ab <= i_cfg_data;
                CFG_EDGE_AC:      r_cfg.edge_ac <= i_cfg_data;
                CFG_UNIT_NORMAL:  r_cfg.unit_normal <= i_cfg_data;
                CFG_PLANE_OFFSET: r_cfg.plane_offset <= i_cfg_data[31:0];
                CFG_INV_GRAM:     r_cfg.inv_gram <= i_cfg_data[31:0];
                CFG_HIT_RADIUS:   r_cfg.hit_radius <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    pti_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );
endmodule

[verif/tb_top.sv]
// Testbench for particle_triangle_impact_top: directed table plus random triangles, self-checked.
`timescale 1ns / 1ps

module tb_top;
    import pti_pkg::*;

    localparam int PhaseItems = 105;
    localparam int NumPhases  = 12;

    typedef struct {
        int   ph;
        t_in  item;
        bit   typed;
        t_out want;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_in         i_data;
    logic        o_valid;
    logic        i_ready;
    t_out        o_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [CfgIdxWidth-1:0]  i_cfg_index;
    logic [CfgDataWidth-1:0] i_cfg_data;

    logic [47:0]        tri_vertex;
    logic [47:0]        tri_ab;
    logic [47:0]        tri_ac;
    logic [47:0]        tri_normal;
    logic signed [31:0] tri_offset;
    logic [31:0]        tri_inv_gram;
    logic [15:0]        tri_radius;

    t_out     pending_vel[$];
    t_dir_row dir_rows[$];
    int       errors;
    int       n_results;
    int       n_hits;
    int       n_writes;
    int       stall_mode;
    int       hold_req;
    int       burst_left;
    bit       gaps_on;

    particle_triangle_impact_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint lane16(logic [47:0] r, int d);
        return longint'($signed(r[16*d +: 16]));
    endfunction

    function automatic longint round_q(longint x, int k);
        return (x + (longint'(1) <<< (k - 1))) >>> k;
    endfunction

    function automatic logic signed [15:0] clamp16(longint x);
        if (x > 32767) return 16'sh7fff;
        if (x < -32768) return 16'sh8000;
        return x[15:0];
    endfunction

    function automatic t_out bounce(t_in it);
        longint p[3], v[3], a[3], e1[3], e2[3], n[3], w[3];
        longint s, side, pdist, radq, sg, off, sq2, sq3, d23, r2, r3, p2, p3, nu, nv, sum, len;
        longint unsigned lim, inv;
        bit in_tri;
        t_out r;
        p[0] = longint'(it.pos_x); p[1] = longint'(it.pos_y); p[2] = longint'(it.pos_z);
        v[0] = longint'(it.vel_x); v[1] = longint'(it.vel_y); v[2] = longint'(it.vel_z);
        s = 0; side = 0; in_tri = 1'b0;
        for (int d = 0; d < 3; d++) begin
            a[d]  = lane16(tri_vertex, d);
            e1[d] = lane16(tri_ab, d);
            e2[d] = lane16(tri_ac, d);
            n[d]  = lane16(tri_normal, d);
            s    += n[d] * p[d];
            side += (a[d] - p[d]) * n[d];
        end
        s += longint'(tri_offset) * 64;
        pdist = (s < 0) ? -s : s;
        radq = longint'(tri_radius) * 16384;
        if (pdist <= radq) begin
            sg = (side > 0) ? -1 : 1;
            sq2 = 0; sq3 = 0; d23 = 0; r2 = 0; r3 = 0;
            for (int d = 0; d < 3; d++) begin
                off  = round_q(sg * pdist * n[d], 20);
                w[d] = (p[d] - a[d]) * 256 - off;
            end
            for (int d = 0; d < 3; d++) begin
                sq2 += e1[d] * e1[d];
                sq3 += e2[d] * e2[d];
                d23 += e1[d] * e2[d];
                r2  += e1[d] * w[d];
                r3  += e2[d] * w[d];
            end
            p2 = round_q(r2, 16);
            p3 = round_q(r3, 16);
            nv = sq3 * p2 - d23 * p3;
            nu = sq2 * p3 - d23 * p2;
            sum = nu + nv;
            inv = longint'(tri_inv_gram);
            if (inv == 0) begin
                in_tri = 1'b1;
            end else begin
                lim = (64'd1 << 40) - 1;
                in_tri = nu >= 0 && nv >= 0 && (sum <= 0 || longint'(unsigned'(sum)) >= 0
                         && unsigned'(sum) <= lim / inv);
            end
        end
        r.hit = in_tri;
        if (in_tri) begin
            len = v[0] * n[0] + v[1] * n[1] + v[2] * n[2];
            r.new_vel_x = clamp16(-v[0] + round_q(2 * len * n[0], 28));
            r.new_vel_y = clamp16(-v[1] + round_q(2 * len * n[1], 28));
            r.new_vel_z = clamp16(-v[2] + round_q(2 * len * n[2], 28));
        end else begin
            r.new_vel_x = it.vel_x;
            r.new_vel_y = it.vel_y;
            r.new_vel_z = it.vel_z;
        end
        return r;
    endfunction

    // Receiver: stall pattern per phase, plus long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            i_ready <= 1'b0;
            hold_req <= hold_req - 1;
        end else begin
            case (stall_mode)
                0: i_ready <= 1'b1;
                1: i_ready <= ($urandom_range(99) >= 30);
                2: i_ready <= ($urandom_range(4) >= 2);
                default: i_ready <= ($urandom_range(99) >= 80);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            n_results++;
            if (pending_vel.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_data);
                errors++;
            end else begin
                want = pending_vel.pop_front();
                if (want.hit != o_data.hit || want.new_vel_x != o_data.new_vel_x ||
                    want.new_vel_y != o_data.new_vel_y || want.new_vel_z != o_data.new_vel_z) begin
                    $display("%0t: mismatch expected hit=%0d v=(%0d,%0d,%0d) actual hit=%0d v=(%0d,%0d,%0d)",
                             $time, want.hit, want.new_vel_x, want.new_vel_y, want.new_vel_z,
                             o_data.hit, o_data.new_vel_x, o_data.new_vel_y, o_data.new_vel_z);
                    errors++;
                end
                if (want.hit) n_hits++;
            end
        end
    end

    task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [47:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_VERTEX_A:     tri_vertex   = value;
            CFG_EDGE_AB:      tri_ab       = value;
            CFG_EDGE_AC:      tri_ac       = value;
            CFG_UNIT_NORMAL:  tri_normal   = value;
            CFG_PLANE_OFFSET: tri_offset   = value[31:0];
            CFG_INV_GRAM:     tri_inv_gram = value[31:0];
            CFG_HIT_RADIUS:   tri_radius   = value[15:0];
            default: ;
        endcase
        n_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic drain();
        wait (pending_vel.size() == 0);
        repeat (12) @(posedge i_clk);
    endtask

    // Offer one request; gaps come between bursts.
    task automatic send_request(t_in it, bit typed, t_out want);
        if (gaps_on && burst_left == 0) begin
            repeat ($urandom_range(6, 1)) begin
                @(negedge i_clk);
                i_valid = 1'b0;
            end
            burst_left = $urandom_range(20, 1);
        end
        if (burst_left > 0) burst_left--;
        @(negedge i_clk);
        i_valid = 1'b1;
        i_data  = it;
        do @(posedge i_clk); while (!o_ready);
        pending_vel.push_back(typed ? want : bounce(it));
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    function automatic t_in mk_item(int px, int py, int pz, int vx, int vy, int vz);
        t_in it;
        it.pos_x = 16'(px); it.pos_y = 16'(py); it.pos_z = 16'(pz);
        it.vel_x = 16'(vx); it.vel_y = 16'(vy); it.vel_z = 16'(vz);
        return it;
    endfunction

    function automatic t_out mk_vel(bit h, int vx, int vy, int vz);
        t_out r;
        r.hit = h; r.new_vel_x = 16'(vx); r.new_vel_y = 16'(vy); r.new_vel_z = 16'(vz);
        return r;
    endfunction

    task automatic add_row(int ph, t_in it, bit typed, t_out want);
        t_dir_row row;
        row.ph = ph; row.item = it; row.typed = typed; row.want = want;
        dir_rows.push_back(row);
    endtask

    function automatic int srand(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic int clip16(int x);
        return (x > 32767) ? 32767 : (x < -32768) ? -32768 : x;
    endfunction

    // Axis-aligned triangle: legs along two axes, normal along the third.
    task automatic load_axis_triangle(int axis, int radius);
        int ai, aj, ak, eu, ev, u, q, nsign;
        logic [47:0] vtx, ab, ac, nrm;
        longint inv;
        u = (axis + 1) % 3;
        q = (axis + 2) % 3;
        ai = srand(-8192, 8191); aj = srand(-8192, 8191); ak = srand(-8192, 8191);
        eu = srand(256, 4096); ev = srand(256, 4096);
        nsign = $urandom_range(1) ? 16384 : -16384;
        vtx = '0; ab = '0; ac = '0; nrm = '0;
        vtx[16*u +: 16] = 16'(ai); vtx[16*q +: 16] = 16'(aj); vtx[16*axis +: 16] = 16'(ak);
        ab[16*u +: 16] = 16'(eu);
        ac[16*q +: 16] = 16'(ev);
        nrm[16*axis +: 16] = 16'(nsign);
        inv = (longint'(1) <<< 48) / (longint'(eu) * eu * ev * ev);
        write_reg(CFG_VERTEX_A, vtx);
        write_reg(CFG_EDGE_AB, ab);
        write_reg(CFG_EDGE_AC, ac);
        write_reg(CFG_UNIT_NORMAL, nrm);
        write_reg(CFG_PLANE_OFFSET, 48'(-(nsign / 64) * ak));
        write_reg(CFG_INV_GRAM, 48'(inv));
        write_reg(CFG_HIT_RADIUS, 48'(radius));
    endtask

    function automatic t_in near_item();
        int p[3];
        t_in it;
        for (int d = 0; d < 3; d++) begin
            p[d] = int'(lane16(tri_vertex, d));
            if (lane16(tri_ab, d) != 0) p[d] += srand(-300, int'(lane16(tri_ab, d)) + 300);
            else if (lane16(tri_ac, d) != 0) p[d] += srand(-300, int'(lane16(tri_ac, d)) + 300);
            else p[d] += srand(-2 * int'(tri_radius) - 64, 2 * int'(tri_radius) + 64);
        end
        it = mk_item(clip16(p[0]), clip16(p[1]), clip16(p[2]), 0, 0, 0);
        {it.vel_z, it.vel_y, it.vel_x} = 48'({$urandom, $urandom});
        return it;
    endfunction

    initial begin
        t_out none;
        int last_ph;
        none = '0;
        errors = 0; n_results = 0; n_hits = 0; n_writes = 0;
        stall_mode = 0; hold_req = 0; burst_left = 0; gaps_on = 1'b0;
        i_rst_n = 1'b0; i_valid = 1'b0; i_data = '0; i_ready = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = CFG_VERTEX_A; i_cfg_data = '0;
        tri_vertex = '0; tri_ab = '0; tri_ac = '0; tri_normal = '0;
        tri_offset = '0; tri_inv_gram = '0; tri_radius = RadiusReset;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset registers: zero normal and zero inv_gram always hit, velocity negated.
        add_row(0, mk_item(0, 0, 0, 1, 2, 3), 1, mk_vel(1, -1, -2, -3));
        add_row(0, mk_item(32767, 32767, 32767, -32768, -32768, -32768), 1,
                mk_vel(1, 32767, 32767, 32767));
        add_row(0, mk_item(-32768, -32768, -32768, 32767, 32767, 32767), 1,
                mk_vel(1, -32767, -32767, -32767));
        add_row(0, mk_item(21845, -21846, 21845, 0, 0, 0), 1, mk_vel(1, 0, 0, 0));
        add_row(0, mk_item(-1, -1, -1, -1, -1, -1), 1, mk_vel(1, 1, 1, 1));
        // Plane offset of 2.0 puts everything beyond the unit radius.
        add_row(1, mk_item(0, 0, 0, 100, -200, 300), 1, mk_vel(0, 100, -200, 300));
        add_row(1, mk_item(-32768, -32768, -32768, -32768, -32768, -32768), 1,
                mk_vel(0, -32768, -32768, -32768));
        add_row(1, mk_item(32767, 32767, 32767, 32767, 32767, 32767), 1,
                mk_vel(0, 32767, 32767, 32767));
        // Right triangle with legs of length 4 in the xy plane.
        add_row(2, mk_item(256, 256, 0, 100, -50, 300), 0, none);
        add_row(2, mk_item(0, 0, 0, -300, 40, -700), 0, none);
        add_row(2, mk_item(0, 512, 0, 5, 5, 5), 0, none);
        add_row(2, mk_item(512, 512, 0, 5, 5, -5), 0, none);
        add_row(2, mk_item(600, 600, 0, 5, 5, 5), 0, none);
        add_row(2, mk_item(-10, 256, 0, 5, 5, 5), 0, none);
        add_row(2, mk_item(256, 256, -200, 1000, 2000, -32768), 0, none);
        add_row(2, mk_item(256, 256, 256, 7, 8, 9), 0, none);
        add_row(2, mk_item(256, 256, 300, 7, 8, 9), 0, none);
        add_row(2, mk_item(300, 200, 100, 32767, -32768, 32767), 0, none);

        last_ph = 0;
        foreach (dir_rows[k]) begin
            if (dir_rows[k].ph != last_ph) begin
                end_burst();
                drain();
                last_ph = dir_rows[k].ph;
                if (last_ph == 1) begin
                    write_reg(CFG_PLANE_OFFSET, 48'h20000);
                end else begin
                    write_reg(CFG_VERTEX_A, '0);
                    write_reg(CFG_EDGE_AB, 48'd1024);
                    write_reg(CFG_EDGE_AC, 48'd1024 << 16);
                    write_reg(CFG_UNIT_NORMAL, 48'd16384 << 32);
                    write_reg(CFG_PLANE_OFFSET, '0);
                    write_reg(CFG_INV_GRAM, 48'd256);
                    write_reg(CFG_HIT_RADIUS, 48'd256);
                    write_reg(3'd7, 48'hFFFF_FFFF_FFFF);
                end
            end
            send_request(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
        end
        end_burst();

        for (int ph = 0; ph < NumPhases; ph++) begin
            drain();
            stall_mode = ph % 4;
            gaps_on = (ph % 3) != 0;
            if (ph == NumPhases - 1) begin
                write_reg(CFG_VERTEX_A, 48'({$urandom, $urandom}));
                write_reg(CFG_EDGE_AB, 48'({$urandom, $urandom}));
                write_reg(CFG_EDGE_AC, 48'({$urandom, $urandom}));
                write_reg(CFG_UNIT_NORMAL, 48'({$urandom, $urandom}));
                write_reg(CFG_PLANE_OFFSET, 48'h8000_0000);
                write_reg(CFG_INV_GRAM, 48'hFFFF_FFFF);
                write_reg(CFG_HIT_RADIUS, 48'hFFFF);
            end else begin
                load_axis_triangle(ph % 3, (ph == 1) ? 0 : (ph == 2) ? 65535 :
                                   int'($urandom_range(1024, 16)));
                if (ph == 4) write_reg(CFG_INV_GRAM, 48'hFFFF_FFFF);
                if (ph == 5) write_reg(CFG_PLANE_OFFSET, 48'h7FFF_FFFF);
                if (ph == 6) write_reg(CFG_INV_GRAM, '0);
            end
            for (int k = 0; k < PhaseItems; k++) begin
                t_in it;
                if (ph == 3 && k == 10) hold_req = 200;
                if ($urandom_range(99) < 80) it = near_item();
                else it = t_in'({$urandom, $urandom, $urandom});
                send_request(it, 1'b0, none);
            end
            end_burst();
        end

        drain();
        $display("Covered %0d results, %0d hits, over %0d register writes and %0d triangle setups.",
                 n_results, n_hits, n_writes, NumPhases + 3);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timeout with %0d results pending", pending_vel.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
